[src/rdse_pkg.sv]
// Shared types, constants and helper functions for the radix digit string encoder.
`default_nettype none

package rdse_pkg;

	// Number format of one input value.
	localparam int INT_BITS    = 47;
	localparam int FRAC_BITS   = 32;
	localparam int FRAC_DIGITS = 16;
	localparam int BASE_W      = 6;
	localparam int CHAR_W      = 7;

	// Division unit: a fixed number of dividend bits is retired each cycle.
	localparam int DIV_RADIX_BITS = 8;
	localparam int DIV_STEPS      = (INT_BITS + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
	localparam int DIV_W          = DIV_STEPS * DIV_RADIX_BITS;
	localparam int STEP_W         = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	// Digit stack that reverses the integer digits.
	localparam int STK_DEPTH  = INT_BITS + 1;
	localparam int STK_ADDR_W = $clog2(STK_DEPTH);
	localparam int STK_CNT_W  = $clog2(STK_DEPTH + 1);

	// Fraction digit counter.
	localparam int FCNT_W = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;

	// Job queue between the front and back parts.
	localparam int JQ_DEPTH = 2;
	localparam int JQ_PTR_W = $clog2(JQ_DEPTH);
	localparam int JQ_CNT_W = $clog2(JQ_DEPTH + 1);

	// Radix limits and character codes.
	localparam logic [BASE_W-1:0] BASE_MIN      = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_MAX      = BASE_W'(36);
	localparam logic [BASE_W-1:0] DEC_DIGIT_MAX = BASE_W'(9);
	localparam logic [CHAR_W-1:0] CHAR_ZERO     = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CHAR_DOT      = CHAR_W'(46);
	localparam logic [CHAR_W-1:0] LETTER_OFFSET = CHAR_W'(55);

	// Fractions at or below this many LSBs (about 1e-9) are treated as exhausted.
	localparam logic [FRAC_BITS-1:0] FRAC_EPS =
		FRAC_BITS'((64'd1 << FRAC_BITS) / 64'd1000000000);

	// One input item.
	typedef struct packed {
		logic [INT_BITS-1:0]  int_part;
		logic [FRAC_BITS-1:0] frac_part;
		logic [BASE_W-1:0]    base;
	} in_item_t;

	// One result item (one character).
	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
		logic              truncated;
	} out_item_t;

	// Classified job handed from the front to the back part.
	typedef struct packed {
		logic [INT_BITS-1:0]  int_val;
		logic [FRAC_BITS-1:0] frac_val;
		logic [BASE_W-1:0]    base;
		logic                 int_zero;
		logic                 has_frac;
	} job_t;

	// Map a digit value to its ASCII character.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
		logic [CHAR_W-1:0] dw;
		dw = CHAR_W'(d);
		if (d > DEC_DIGIT_MAX) begin
			return dw + LETTER_OFFSET;
		end
		return dw + CHAR_ZERO;
	endfunction

endpackage

`default_nettype wire

[src/rdse_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rdse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[src/rdse_front.sv]
// Front part: accepts input items, classifies them and queues them as jobs.
`default_nettype none

module rdse_front
	import rdse_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t item,
	output logic          job_valid,
	input  wire logic     job_pop,
	output job_t          job
);

	job_t                job_new;
	job_t                jq_q [JQ_DEPTH];
	logic [JQ_PTR_W-1:0] wr_ptr_q;
	logic [JQ_PTR_W-1:0] rd_ptr_q;
	logic [JQ_CNT_W-1:0] cnt_q;
	logic                acc;
	logic                take;

	// Clamp the radix and flag the special cases of the value.
	always_comb begin
		job_new.int_val  = item.int_part;
		job_new.frac_val = item.frac_part;
		if (item.base < BASE_MIN) begin
			job_new.base = BASE_MIN;
		end else if (item.base > BASE_MAX) begin
			job_new.base = BASE_MAX;
		end else begin
			job_new.base = item.base;
		end
		job_new.int_zero = (item.int_part == '0);
		job_new.has_frac = (item.frac_part > FRAC_EPS);
	end

	assign full      = (cnt_q == JQ_CNT_W'(JQ_DEPTH));
	assign job_valid = (cnt_q != '0);
	assign job       = jq_q[rd_ptr_q];
	assign acc       = push && !full;
	assign take      = job_pop && job_valid;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (acc) begin
			jq_q[wr_ptr_q] <= job_new;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (acc) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (acc && !take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (take && !acc) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[src/rdse_back.sv]
// Back part: divides out the integer digits, emits them, then the fraction digits.
`default_nettype none

module rdse_back
	import rdse_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic job_valid,
	output logic      job_pop,
	input  wire job_t job,
	output logic      empty,
	input  wire logic pop,
	output out_item_t result
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_EMIT = 5'b00100,
		ST_DOT  = 5'b01000,
		ST_FRAC = 5'b10000
	} state_t;

	state_t                      state_q;
	logic [DIV_W-1:0]            dvd_q;
	logic [BASE_W-1:0]           rem_q;
	logic [STEP_W-1:0]           step_q;
	logic [STK_CNT_W-1:0]        cnt_q;
	logic [FRAC_BITS-1:0]        frac_q;
	logic [BASE_W-1:0]           base_q;
	logic                        has_frac_q;
	logic [FCNT_W-1:0]           fcnt_q;
	logic                        rd_vld_q;
	out_item_t                   out_q;
	logic                        out_vld_q;

	logic [BASE_W:0]             trial;
	logic [BASE_W-1:0]           rem_v;
	logic [DIV_RADIX_BITS-1:0]   qbits;
	logic [DIV_W-1:0]            quot_n;
	logic                        div_last;

	logic [FRAC_BITS+BASE_W-1:0] prod;
	logic [FRAC_BITS-1:0]        frac_n;
	logic [BASE_W-1:0]           fdigit;
	logic                        frac_full;
	logic                        frac_done;

	logic                        out_rdy;
	logic                        emit;
	out_item_t                   emit_item;

	logic                        wr_en;
	logic [STK_ADDR_W-1:0]       wr_addr;
	logic [BASE_W-1:0]           wr_data;
	logic                        rd_en;
	logic [STK_ADDR_W-1:0]       rd_addr;
	logic [STK_CNT_W-1:0]        rd_idx;
	logic [BASE_W-1:0]           rd_data;

	// Restoring division: several quotient bits per cycle, remainder stays narrow.
	always_comb begin
		rem_v = rem_q;
		qbits = '0;
		trial = '0;
		for (int i = 0; i < DIV_RADIX_BITS; i++) begin
			trial = {rem_v, dvd_q[DIV_W-1-i]};
			if (trial >= {1'b0, base_q}) begin
				qbits[DIV_RADIX_BITS-1-i] = 1'b1;
				rem_v = BASE_W'(trial - {1'b0, base_q});
			end else begin
				rem_v = trial[BASE_W-1:0];
			end
		end
	end

	assign quot_n   = (dvd_q << DIV_RADIX_BITS) | DIV_W'(qbits);
	assign div_last = (step_q == STEP_W'(DIV_STEPS - 1));

	// One fraction digit: multiply by the base, split off the integer bits.
	assign prod      = (FRAC_BITS + BASE_W)'(frac_q) * (FRAC_BITS + BASE_W)'(base_q);
	assign fdigit    = prod[FRAC_BITS +: BASE_W];
	assign frac_n    = prod[FRAC_BITS-1:0];
	assign frac_full = (fcnt_q == FCNT_W'(FRAC_DIGITS - 1));
	assign frac_done = (frac_n <= FRAC_EPS) || frac_full;

	// Output register accepts a character when empty or being drained.
	assign out_rdy = !out_vld_q || pop;
	assign empty   = !out_vld_q;
	assign result  = out_q;
	assign job_pop = (state_q == ST_IDLE) && job_valid;

	// Digit stack write: a zero integer part or the remainder of each division.
	assign wr_en   = ((state_q == ST_IDLE) && job_valid && job.int_zero)
	               || ((state_q == ST_DIV) && div_last);
	assign wr_addr = cnt_q[STK_ADDR_W-1:0];
	assign wr_data = (state_q == ST_IDLE) ? '0 : rem_v;

	// Digit stack read, popping from the most significant digit.
	assign rd_en   = (state_q == ST_EMIT)
	               && (!rd_vld_q || (out_rdy && (cnt_q > STK_CNT_W'(1))));
	assign rd_idx  = rd_vld_q ? (cnt_q - STK_CNT_W'(2)) : (cnt_q - STK_CNT_W'(1));
	assign rd_addr = rd_idx[STK_ADDR_W-1:0];

	rdse_ram #(
		.WIDTH(BASE_W),
		.DEPTH(STK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Select the character produced this cycle, if any.
	always_comb begin
		emit      = 1'b0;
		emit_item = '0;
		unique case (state_q)
			ST_EMIT: begin
				emit                = rd_vld_q && out_rdy;
				emit_item.character = digit_char(rd_data);
				emit_item.last      = (cnt_q == STK_CNT_W'(1)) && !has_frac_q;
			end
			ST_DOT: begin
				emit                = out_rdy;
				emit_item.character = CHAR_DOT;
			end
			ST_FRAC: begin
				emit                = out_rdy;
				emit_item.character = digit_char(fdigit);
				emit_item.last      = frac_done;
				emit_item.truncated = frac_full && (frac_n > FRAC_EPS);
			end
			ST_IDLE, ST_DIV: begin
				emit = 1'b0;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			dvd_q      <= '0;
			rem_q      <= '0;
			step_q     <= '0;
			cnt_q      <= '0;
			frac_q     <= '0;
			base_q     <= BASE_MIN;
			has_frac_q <= 1'b0;
			fcnt_q     <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						dvd_q      <= DIV_W'(job.int_val);
						rem_q      <= '0;
						step_q     <= '0;
						frac_q     <= job.frac_val;
						base_q     <= job.base;
						has_frac_q <= job.has_frac;
						fcnt_q     <= '0;
						rd_vld_q   <= 1'b0;
						if (job.int_zero) begin
							cnt_q   <= STK_CNT_W'(1);
							state_q <= ST_EMIT;
						end else begin
							cnt_q   <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					dvd_q <= quot_n;
					if (div_last) begin
						cnt_q  <= cnt_q + 1'b1;
						step_q <= '0;
						rem_q  <= '0;
						if (quot_n == '0) begin
							state_q <= ST_EMIT;
						end
					end else begin
						step_q <= step_q + 1'b1;
						rem_q  <= rem_v;
					end
				end
				ST_EMIT: begin
					if (rd_en) begin
						rd_vld_q <= 1'b1;
					end
					if (emit) begin
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == STK_CNT_W'(1)) begin
							rd_vld_q <= 1'b0;
							state_q  <= has_frac_q ? ST_DOT : ST_IDLE;
						end
					end
				end
				ST_DOT: begin
					if (out_rdy) begin
						state_q <= ST_FRAC;
					end
				end
				ST_FRAC: begin
					if (out_rdy) begin
						frac_q <= frac_n;
						fcnt_q <= fcnt_q + 1'b1;
						if (frac_done) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_q     <= '0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
			out_q     <= emit_item;
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[src/radix_digit_string_encoder.sv]
// Radix digit string encoder: top level joining the front and back parts.
//
// Input channel: an item (integer part, binary fraction, base) is transferred
// when push is high and full is low. Result channel: each character waits on
// result while empty is low and is transferred when pop is high.
// A number gives 1 to 64 characters: the integer digits, most significant
// first, then '.' and up to 16 fraction digits when the fraction is not
// negligible. The final character has last set, and truncated when fraction
// remained after the last fraction digit.
// Operation: the divider retires 8 dividend bits a cycle, so each integer
// digit takes a full pass over the dividend; digits are popped from a stack
// RAM at one per cycle while the receiver keeps up, and each fraction digit
// comes from one multiply by the base. A two-entry job queue lets new items
// be transferred while the back part is still working.
// Reset clears the queue, the sequencer and the output register; nothing
// else needs clearing. When the receiver stalls, the current character holds
// and the back part waits; the front keeps accepting until its queue fills.
`default_nettype none

module radix_digit_string_encoder
	import rdse_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t item,
	output logic          empty,
	input  wire logic     pop,
	output out_item_t     result
);

	logic job_valid;
	logic job_pop;
	job_t job;

	rdse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.job_valid(job_valid),
		.job_pop  (job_pop),
		.job      (job)
	);

	rdse_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job_pop  (job_pop),
		.job      (job),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

	// A transferred item is queued for the back part on the next cycle.
	a_push_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> job_valid)
		else $error("accepted item not visible to the back part");

	// The truncation flag only ever rides on the final character.
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.truncated) |-> result.last)
		else $error("truncated set on a character that is not last");

	// Every character shown is a digit, an uppercase letter or the point.
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((result.character >= CHAR_ZERO
			&& result.character <= (CHAR_ZERO + CHAR_W'(9)))
			|| (result.character >= (LETTER_OFFSET + CHAR_W'(10))
			&& result.character <= (LETTER_OFFSET + CHAR_W'(35)))
			|| (result.character == CHAR_DOT)))
		else $error("illegal character on the result port");

endmodule

`default_nettype wire

[tb/digit_string_checker.sv]
// Checker for the radix digit string encoder: watches both channels and predicts every character.
`default_nettype none

module digit_string_checker
	import rdse_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire logic      full,
	input  wire in_item_t  item,
	input  wire logic      empty,
	input  wire logic      pop,
	input  wire out_item_t result,
	output int             fail_cnt,
	output int             pending
);

	// Characters still owed by the block, oldest first.
	out_item_t expected_chars[$];
	int        errors = 0;

	initial begin
		fail_cnt = 0;
		pending  = 0;
	end

	// ASCII code of one digit value.
	function automatic out_item_t digit_to_char(input logic [BASE_W-1:0] d);
		out_item_t ch;
		ch = '0;
		if (d > DEC_DIGIT_MAX) begin
			ch.character = CHAR_W'(d) + LETTER_OFFSET;
		end else begin
			ch.character = CHAR_W'(d) + CHAR_ZERO;
		end
		return ch;
	endfunction

	// Work out the full character string of one number and queue it.
	task automatic encode_number(input in_item_t num);
		logic [INT_BITS-1:0]  ival;
		logic [FRAC_BITS-1:0] frac;
		logic [BASE_W-1:0]    radix;
		logic [63:0]          prod;
		logic [BASE_W-1:0]    int_digits[$];
		logic [BASE_W-1:0]    frac_digits[$];
		out_item_t            chars[$];
		out_item_t            tail;
		logic                 trunc;
		ival  = num.int_part;
		frac  = num.frac_part;
		radix = num.base;

		// Out-of-range bases are clamped to the nearest legal one.
		if (radix < BASE_MIN) begin
			radix = BASE_MIN;
		end
		if (radix > BASE_MAX) begin
			radix = BASE_MAX;
		end

		// Fraction digits by repeated multiplication, exact in 64 bits.
		while (frac > FRAC_EPS && frac_digits.size() < FRAC_DIGITS) begin
			prod = 64'(frac) * 64'(radix);
			frac_digits.push_back(BASE_W'(prod >> FRAC_BITS));
			frac = prod[FRAC_BITS-1:0];
		end
		trunc = (frac_digits.size() > 0) && (frac > FRAC_EPS);

		// Integer digits by repeated division, built most significant first.
		if (ival == '0) begin
			int_digits.push_front('0);
		end
		while (ival != '0) begin
			int_digits.push_front(BASE_W'(ival % radix));
			ival = ival / radix;
		end

		foreach (int_digits[i]) begin
			chars.push_back(digit_to_char(int_digits[i]));
		end
		if (frac_digits.size() > 0) begin
			tail = '0;
			tail.character = CHAR_DOT;
			chars.push_back(tail);
			foreach (frac_digits[i]) begin
				chars.push_back(digit_to_char(frac_digits[i]));
			end
		end

		// Only the final character carries the end and truncation flags.
		tail = chars[chars.size()-1];
		tail.last = 1'b1;
		tail.truncated = trunc;
		chars[chars.size()-1] = tail;
		foreach (chars[i]) begin
			expected_chars.push_back(chars[i]);
		end
	endtask

	// Predict on every input transfer and compare on every result transfer.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (push && !full) begin
				encode_number(item);
			end
			if (pop && !empty) begin
				if (expected_chars.size() == 0) begin
					errors++;
					$display("%0t: unexpected character: got char %h last %b trunc %b",
						$time, result.character, result.last, result.truncated);
				end else begin
					want = expected_chars.pop_front();
					if (result.character !== want.character || result.last !== want.last ||
						result.truncated !== want.truncated) begin
						errors++;
						$display("%0t: expected char %h last %b trunc %b, got char %h last %b trunc %b",
							$time, want.character, want.last, want.truncated,
							result.character, result.last, result.truncated);
					end
				end
			end
		end
		fail_cnt <= errors;
		pending  <= expected_chars.size();
	end

endmodule

`default_nettype wire

[tb/testbench.sv]
// Top of the radix digit string encoder testbench: clock, reset, stimulus and verdict.
`default_nettype none

module testbench;
	import rdse_pkg::*;

	localparam int NUM_RANDOM   = 420;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 400;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	logic      pop;
	out_item_t result;
	int        fail_cnt;
	int        pending;
	int        push_slack;
	int        pop_slack;
	int        quiet_cycles = 0;

	radix_digit_string_encoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	digit_string_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.fail_cnt (fail_cnt),
		.pending  (pending)
	);

	// Clock with a period of 4.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Largest idle gap for a stretch of transfers; zero gives back-to-back traffic.
	function automatic int pick_slack();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 2;
			default: return 9;
		endcase
	endfunction

	function automatic in_item_t number(input logic [INT_BITS-1:0] ip,
		input logic [FRAC_BITS-1:0] fp, input logic [BASE_W-1:0] b);
		in_item_t n;
		n.int_part  = ip;
		n.frac_part = fp;
		n.base      = b;
		return n;
	endfunction

	// Random number: mixed integer widths, short and long fractions, mostly legal bases.
	function automatic in_item_t random_number();
		logic [63:0] wide;
		int          bits;
		in_item_t    n;
		bits = $urandom_range(1, INT_BITS);
		wide = {$urandom, $urandom};
		n.int_part = INT_BITS'(wide & ((64'd1 << bits) - 64'd1));
		if ($urandom_range(0, 9) == 0) begin
			n.int_part = '0;
		end
		case ($urandom_range(0, 9))
			0: n.frac_part = '0;
			1: n.frac_part = FRAC_BITS'($urandom_range(0, 8));
			2, 3: n.frac_part = $urandom << $urandom_range(24, 31);
			default: n.frac_part = $urandom;
		endcase
		if ($urandom_range(0, 19) == 0) begin
			n.base = BASE_W'($urandom_range(0, 63));
		end else begin
			n.base = BASE_W'($urandom_range(2, 36));
		end
		return n;
	endfunction

	// Offer one number after a random gap and hold it until the transfer.
	task automatic send_number(input in_item_t n);
		int gap;
		gap = $urandom_range(0, push_slack);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		item <= n;
		do @(posedge clk); while (full !== 1'b0);
		@(negedge clk);
	endtask

	// Stimulus and verdict.
	initial begin
		in_item_t plan[$];
		arst_n     = 1'b0;
		push       = 1'b0;
		pop        = 1'b0;
		item       = '0;
		push_slack = 5;
		pop_slack  = 5;

		// Field extremes, base clamping, tiny and truncated fractions, letter digits.
		plan.push_back(number('0, '0, 6'd10));
		plan.push_back(number('1, '0, 6'd2));
		plan.push_back(number('1, '1, 6'd2));
		plan.push_back(number('1, '1, 6'd36));
		plan.push_back(number('0, 32'h8000_0000, 6'd2));
		plan.push_back(number('0, 32'd4, 6'd10));
		plan.push_back(number('0, 32'd5, 6'd10));
		plan.push_back(number('0, 32'd1, 6'd16));
		plan.push_back(number(47'd123, 32'h5555_5555, 6'd10));
		plan.push_back(number('0, 32'h5555_5556, 6'd3));
		plan.push_back(number(47'd35, '0, 6'd36));
		plan.push_back(number(47'd255, '0, 6'd0));
		plan.push_back(number(47'd255, '0, 6'd1));
		plan.push_back(number(47'd1295, '0, 6'd37));
		plan.push_back(number(47'd1295, '0, 6'd63));
		plan.push_back(number(47'd10, 32'h4000_0000, 6'd16));
		plan.push_back(number(47'd9, '0, 6'd10));
		plan.push_back(number(47'd10, '0, 6'd11));
		plan.push_back(number(47'd12345, 32'hC000_0000, 6'd8));
		plan.push_back(number(47'h5555_5555_5555, 32'hAAAA_AAAA, 6'd7));
		plan.push_back(number(47'h2AAA_AAAA_AAAA, 32'h5555_5555, 6'd31));
		plan.push_back(number('0, '1, 6'd36));

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			send_number(plan[i]);
		end
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n % 40 == 0) begin
				push_slack = pick_slack();
			end
			send_number(random_number());
		end
		push <= 1'b0;

		// Let every owed character arrive, then watch for strays.
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Result side: a random gap before each transfer, with changing stall levels.
	initial begin
		int gap;
		int taken;
		taken = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (taken % 100 == 0) begin
				pop_slack = pick_slack();
			end
			gap = $urandom_range(0, pop_slack);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty !== 1'b0);
			taken++;
			@(negedge clk);
		end
	end

	// Watchdog: too long without any transfer on either side ends the run.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

`default_nettype wire
